// ===== rtl/aia_pkg.sv =====
package aia_pkg;

   localparam int DATA_WIDTH          = 64;
   localparam int HALF_WIDTH          = DATA_WIDTH / 2;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [5:0] OP_ADD       = 6'd0;
   localparam logic [5:0] OP_ADC       = 6'd1;
   localparam logic [5:0] OP_ADDS      = 6'd2;
   localparam logic [5:0] OP_ADCS      = 6'd3;
   localparam logic [5:0] OP_SUB       = 6'd4;
   localparam logic [5:0] OP_SBC       = 6'd5;
   localparam logic [5:0] OP_SUBS      = 6'd6;
   localparam logic [5:0] OP_SBCS      = 6'd7;
   localparam logic [5:0] OP_AND       = 6'd8;
   localparam logic [5:0] OP_ANDS      = 6'd9;
   localparam logic [5:0] OP_BIC       = 6'd10;
   localparam logic [5:0] OP_BICS      = 6'd11;
   localparam logic [5:0] OP_ORR       = 6'd12;
   localparam logic [5:0] OP_ORN       = 6'd13;
   localparam logic [5:0] OP_EOR       = 6'd14;
   localparam logic [5:0] OP_EON       = 6'd15;
   localparam logic [5:0] OP_NOT       = 6'd16;
   localparam logic [5:0] OP_LSL       = 6'd17;
   localparam logic [5:0] OP_LSR       = 6'd18;
   localparam logic [5:0] OP_ASR       = 6'd19;
   localparam logic [5:0] OP_ROR       = 6'd20;
   localparam logic [5:0] OP_SXTB      = 6'd21;
   localparam logic [5:0] OP_SXTH      = 6'd22;
   localparam logic [5:0] OP_SXTW      = 6'd23;
   localparam logic [5:0] OP_UXTB      = 6'd24;
   localparam logic [5:0] OP_UXTH      = 6'd25;
   localparam logic [5:0] OP_UXTW      = 6'd26;
   localparam logic [5:0] OP_MUL       = 6'd27;
   localparam logic [5:0] OP_UMULH     = 6'd28;
   localparam logic [5:0] OP_SMULH     = 6'd29;
   localparam logic [5:0] OP_UMULL     = 6'd30;
   localparam logic [5:0] OP_SMULL     = 6'd31;
   localparam logic [5:0] OP_UDIV      = 6'd32;
   localparam logic [5:0] OP_SDIV      = 6'd33;
   localparam logic [5:0] OP_MOV       = 6'd34;
   localparam logic [5:0] OP_MOVN      = 6'd35;
   localparam logic [5:0] OP_MOVK      = 6'd36;
   localparam logic [5:0] OP_OVERWRITE = 6'd37;
   localparam logic [5:0] OP_CONCAT32  = 6'd38;
   localparam logic [5:0] OP_CONCAT64  = 6'd39;

   typedef struct packed {
      logic [5:0]            cmd;
      logic [DATA_WIDTH-1:0] op_a;
      logic [DATA_WIDTH-1:0] op_b;
      logic [DATA_WIDTH-1:0] op_c;
      logic                  size_64;
      logic                  cflag;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] result;
      logic [DATA_WIDTH-1:0] result_high;
      logic                  wide_result;
      logic [3:0]            flags_nzcv;
      logic                  flags_valid;
   } rsp_type;

   typedef enum logic [1:0] {
      CLS_FAST = 2'd0,
      CLS_MUL  = 2'd1,
      CLS_DIV  = 2'd2
   } cls_type;

   typedef struct packed {
      req_type req;
      cls_type cls;
   } entry_type;

   typedef struct packed {
      logic                  start;
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
      logic                  negate;
      logic                  size_64;
   } div_cmd_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DATA_WIDTH-1:0] quotient;
   } div_sts_type;

endpackage

// ===== rtl/aia_front.sv =====
module aia_front
   import aia_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      head_valid,
   output entry_type head,
   input  logic      pop
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

   entry_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   entry_type       ent;
   logic            push, take;

   // classify by unit
   always_comb begin
      ent.req = req_data;
      case (req_data.cmd) inside
         [OP_MUL:OP_SMULL]:  ent.cls = CLS_MUL;
         OP_UDIV, OP_SDIV:   ent.cls = CLS_DIV;
         default:            ent.cls = CLS_FAST;
      endcase
   end

   assign req_ready  = (cnt_ff != FULL);
   assign push       = req_valid && req_ready;
   assign head_valid = (cnt_ff != '0);
   assign take       = pop && head_valid;
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = take ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= ent;
      end
   end

endmodule

// ===== rtl/aia_div.sv =====
module aia_div
   import aia_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   input  logic        take,
   output div_sts_type sts
);

   localparam int CNTW = $clog2(DATA_WIDTH);
   localparam logic [CNTW-1:0] LAST_STEP = CNTW'(DATA_WIDTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic                  neg_ff, neg_in, sz_ff, sz_in;
   logic [DATA_WIDTH:0]   shifted, diff;
   logic                  ge;
   logic [DATA_WIDTH-1:0] q;

   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = (shifted >= {1'b0, dsr_ff});
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      neg_in   = neg_ff;
      sz_in    = sz_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               rem_in   = '0;
               quo_in   = cmd.dividend;
               dsr_in   = cmd.divisor;
               neg_in   = cmd.negate;
               sz_in    = cmd.size_64;
            end
         end
         ST_RUN: begin
            rem_in = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
      sz_ff  <= sz_in;
   end

   // zero divisor gives zero; sign fix and size mask on the way out
   always_comb begin
      q = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
      if (dsr_ff == '0) begin
         q = '0;
      end
      if (!sz_ff) begin
         q = {{HALF_WIDTH{1'b0}}, q[HALF_WIDTH-1:0]};
      end
      sts.busy     = (state_ff != ST_IDLE);
      sts.done     = (state_ff == ST_DONE);
      sts.quotient = q;
   end

endmodule

// ===== rtl/aia_back.sv =====
module aia_back
   import aia_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int DW = DATA_WIDTH;
   localparam int HW = HALF_WIDTH;

   typedef struct packed {
      logic          is_mul;
      logic [5:0]    cmd;
      rsp_type       fast;
      logic [DW-1:0] ll, lh, hl, hh;
      logic [DW-1:0] corr_h, corr_l;
   } s1_type;

   typedef struct packed {
      logic          is_mul;
      logic [5:0]    cmd;
      rsp_type       fast;
      logic [2*DW-1:0] prod;
      logic [DW-1:0] ll;
      logic [DW-1:0] corr_h, corr_l;
   } s2_type;

   logic        s1_vld_ff, s1_vld_in, s2_vld_ff, out_vld_ff;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   rsp_type     out_ff, out_in;
   logic        advance;
   div_cmd_type dcmd;
   div_sts_type dsts;

   req_type       r;
   logic [DW-1:0] m, xa, xb, y, s, res, sxa, sa, sb, ua, ub;
   logic [DW:0]   sum;
   logic          cin, c, n, v, is_sub;
   logic [5:0]    amt;
   logic [2*DW-1:0] rr64;
   logic [DW-1:0]   rr32;
   rsp_type       fast;
   logic          pop_fast, start_div;

   aia_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .take  (advance && dsts.done),
      .sts   (dsts)
   );

   assign advance = !out_vld_ff || rsp_ready;

   // fast operations, computed combinationally from the queue head
   always_comb begin
      r      = head.req;
      m      = r.size_64 ? '1 : {{HW{1'b0}}, {HW{1'b1}}};
      xa     = r.op_a & m;
      xb     = r.op_b & m;
      is_sub = r.cmd inside {OP_SUB, OP_SBC, OP_SUBS, OP_SBCS};
      y      = (is_sub ? ~r.op_b : r.op_b) & m;
      case (r.cmd) inside
         OP_ADD, OP_ADDS: cin = 1'b0;
         OP_SUB, OP_SUBS: cin = 1'b1;
         default:         cin = r.cflag;
      endcase
      sum = {1'b0, xa} + {1'b0, y} + {{DW{1'b0}}, cin};
      s   = r.size_64 ? sum[DW-1:0] : {{HW{1'b0}}, sum[HW-1:0]};
      c   = r.size_64 ? sum[DW] : sum[HW];
      n   = r.size_64 ? s[DW-1] : s[HW-1];
      v   = r.size_64 ? ((xa[DW-1] ^ s[DW-1]) & (y[DW-1] ^ s[DW-1]))
                      : ((xa[HW-1] ^ s[HW-1]) & (y[HW-1] ^ s[HW-1]));
      amt  = r.size_64 ? r.op_b[5:0] : {1'b0, r.op_b[4:0]};
      sxa  = r.size_64 ? xa : {{HW{xa[HW-1]}}, xa[HW-1:0]};
      rr64 = {xa, xa} >> amt;
      rr32 = {xa[HW-1:0], xa[HW-1:0]} >> amt[4:0];

      fast = '0;
      res  = '0;
      case (r.cmd)
         OP_ADD, OP_ADC, OP_SUB, OP_SBC: res = s;
         OP_ADDS, OP_ADCS, OP_SUBS, OP_SBCS: begin
            res              = s;
            fast.flags_nzcv  = {n, (s == '0), c, v};
            fast.flags_valid = 1'b1;
         end
         OP_AND, OP_ANDS: res = r.op_a & r.op_b;
         OP_BIC, OP_BICS: res = r.op_a & ~r.op_b;
         OP_ORR:  res = r.op_a | r.op_b;
         OP_ORN:  res = r.op_a | ~r.op_b;
         OP_EOR:  res = r.op_a ^ r.op_b;
         OP_EON:  res = r.op_a ^ ~r.op_b;
         OP_NOT, OP_MOVN: res = ~r.op_a;
         OP_LSL:  res = xa << amt;
         OP_LSR:  res = xa >> amt;
         OP_ASR:  res = DW'($signed(sxa) >>> amt);
         OP_ROR:  res = r.size_64 ? rr64[DW-1:0] : {{HW{1'b0}}, rr32[HW-1:0]};
         OP_SXTB: res = {{(DW-8){r.op_a[7]}}, r.op_a[7:0]};
         OP_SXTH: res = {{(DW-16){r.op_a[15]}}, r.op_a[15:0]};
         OP_SXTW: res = {{HW{r.op_a[HW-1]}}, r.op_a[HW-1:0]};
         OP_UXTB: res = {{(DW-8){1'b0}}, r.op_a[7:0]};
         OP_UXTH: res = {{(DW-16){1'b0}}, r.op_a[15:0]};
         OP_UXTW: res = {{HW{1'b0}}, r.op_a[HW-1:0]};
         OP_MOV:  res = r.op_a;
         OP_MOVK: res = (r.op_b & r.op_c) | r.op_a;
         OP_OVERWRITE: res = (r.op_a & r.op_c) | r.op_b;
         OP_CONCAT32: begin
            res              = {r.op_a[HW-1:0], r.op_b[HW-1:0]};
            fast.wide_result = 1'b1;
         end
         OP_CONCAT64: begin
            res              = r.op_b;
            fast.result_high = r.op_a;
            fast.wide_result = 1'b1;
         end
         default: res = '0;
      endcase
      if (r.cmd inside {[OP_ADD:OP_UXTW], [OP_MOV:OP_OVERWRITE]}) begin
         res = res & m;
      end
      if (r.cmd inside {OP_ANDS, OP_BICS}) begin
         fast.flags_nzcv  = {(r.size_64 ? res[DW-1] : res[HW-1]), (res == '0), 2'b00};
         fast.flags_valid = 1'b1;
      end
      fast.result = res;
   end

   // divider operands
   always_comb begin
      sa = r.size_64 ? r.op_a : {{HW{r.op_a[HW-1]}}, r.op_a[HW-1:0]};
      sb = r.size_64 ? r.op_b : {{HW{r.op_b[HW-1]}}, r.op_b[HW-1:0]};
      if (r.cmd == OP_SDIV) begin
         ua = sa[DW-1] ? (~sa + 1'b1) : sa;
         ub = sb[DW-1] ? (~sb + 1'b1) : sb;
      end else begin
         ua = xa;
         ub = xb;
      end
      start_div     = head_valid && (head.cls == CLS_DIV) && !dsts.busy;
      dcmd.start    = start_div;
      dcmd.dividend = ua;
      dcmd.divisor  = ub;
      dcmd.negate   = (r.cmd == OP_SDIV) && (sa[DW-1] != sb[DW-1]);
      dcmd.size_64  = r.size_64;
   end

   // a busy divider holds the queue so results stay in order
   assign pop_fast = head_valid && (head.cls != CLS_DIV) && !dsts.busy && advance;
   assign pop      = pop_fast || start_div;

   always_comb begin
      s1_in        = '0;
      s1_in.cmd    = r.cmd;
      s1_in.fast   = fast;
      s1_in.is_mul = (head.cls == CLS_MUL);
      s1_in.ll     = DW'(r.op_a[HW-1:0] * r.op_b[HW-1:0]);
      s1_in.lh     = DW'(r.op_a[HW-1:0] * r.op_b[DW-1:HW]);
      s1_in.hl     = DW'(r.op_a[DW-1:HW] * r.op_b[HW-1:0]);
      s1_in.hh     = DW'(r.op_a[DW-1:HW] * r.op_b[DW-1:HW]);
      s1_in.corr_h = (r.op_a[DW-1] ? r.op_b : '0) + (r.op_b[DW-1] ? r.op_a : '0);
      s1_in.corr_l = (r.op_a[HW-1] ? {r.op_b[HW-1:0], {HW{1'b0}}} : '0)
                   + (r.op_b[HW-1] ? {r.op_a[HW-1:0], {HW{1'b0}}} : '0);
      s1_vld_in    = pop_fast;
      if (dsts.done) begin
         s1_in             = '0;
         s1_in.fast.result = dsts.quotient;
         s1_vld_in         = 1'b1;
      end
   end

   always_comb begin
      s2_in        = '0;
      s2_in.is_mul = s1_ff.is_mul;
      s2_in.cmd    = s1_ff.cmd;
      s2_in.fast   = s1_ff.fast;
      s2_in.ll     = s1_ff.ll;
      s2_in.corr_h = s1_ff.corr_h;
      s2_in.corr_l = s1_ff.corr_l;
      s2_in.prod   = {s1_ff.hh, s1_ff.ll}
                   + {{HW{1'b0}}, s1_ff.lh, {HW{1'b0}}}
                   + {{HW{1'b0}}, s1_ff.hl, {HW{1'b0}}};
   end

   always_comb begin
      out_in = s2_ff.fast;
      if (s2_ff.is_mul) begin
         out_in = '0;
         case (s2_ff.cmd)
            OP_MUL:   out_in.result = s2_ff.prod[DW-1:0];
            OP_UMULH: out_in.result = s2_ff.prod[2*DW-1:DW];
            OP_SMULH: out_in.result = s2_ff.prod[2*DW-1:DW] - s2_ff.corr_h;
            OP_UMULL: out_in.result = s2_ff.ll;
            OP_SMULL: out_in.result = s2_ff.ll - s2_ff.corr_l;
            default:  out_in.result = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s1_vld_ff;
         out_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/aarch64_integer_alu.sv =====
// Path: a response is offered once its request has passed the queue, the two
//   multiply stages and the output register; a divide also runs through the shared
//   one-bit-per-step divider, which holds the requests behind it in the queue.
// Throughput: one request per cycle while the output flows and no divide runs.
// Reset: synchronous, active high; empties the queue, pipeline and divider.
module aarch64_integer_alu
   import aia_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      head_valid;
   entry_type head;
   logic      pop;

   // front: take requests, tag the unit, hold them in a short queue
   aia_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   // back: fast ops, pipelined 32x32 partial-product multiplier, serial divider
   aia_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/aia_checker.sv =====
module aia_checker
   import aia_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready right after reset");

   a_flags_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.flags_valid |-> rsp_data.flags_nzcv == 4'd0)
      else $error("flags set on non-flag op");

   a_high_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.wide_result |-> rsp_data.result_high == '0)
      else $error("high half set on narrow result");

endmodule

bind aarch64_integer_alu aia_checker u_aia_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/aarch64_integer_alu_tb.sv =====
`timescale 1ns / 100ps

module aarch64_integer_alu_tb;
   import aia_pkg::*;

   localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LO32  = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MIN32 = 64'h0000_0000_8000_0000;
   localparam logic [5:0]  OP_FIRST_UNUSED = 6'd40;
   localparam int          N_RANDOM = 1280;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   aarch64_integer_alu dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Responses still owed by the unit, oldest first
   rsp_type pending_rsp[$];
   int      n_errors    = 0;
   int      n_checked   = 0;
   int      n_sent      = 0;
   int      n_flag_ops  = 0;
   int      n_div_ops   = 0;

   // Idle percentages for each side; changed between phases.
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_off      = 1'b0;
   bit      stim_done     = 1'b0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      n_errors++;
      $display("%0t: mismatch %s got %h expected %h", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------
   // Result prediction
   // ---------------------------------------------------------------
   function automatic logic [63:0] sext(input logic [63:0] x, input int bits);
      logic [63:0] m;
      m = (bits >= 64) ? ONES : ((64'd1 << bits) - 64'd1);
      x = x & m;
      if (bits < 64 && x[bits-1]) return x | ~m;
      return x;
   endfunction

   // x + y + cin at 32 or 64 bits, with NZCV
   function automatic logic [63:0] add_nzcv(input logic [63:0] x, input logic [63:0] y,
                                            input logic cin, input bit wide,
                                            output logic [3:0] nzcv);
      logic [64:0] full;
      logic [63:0] s;
      logic        c, n, v;
      if (wide) begin
         full = {1'b0, x} + {1'b0, y} + 65'(cin);
         s = full[63:0];
         c = full[64];
         n = s[63];
         v = (x[63] == y[63]) && (s[63] != x[63]);
      end else begin
         full = {33'd0, x[31:0]} + {33'd0, y[31:0]} + 65'(cin);
         s = {32'd0, full[31:0]};
         c = full[32];
         n = s[31];
         v = (x[31] == y[31]) && (s[31] != x[31]);
      end
      nzcv = {n, s == 64'd0, c, v};
      return s;
   endfunction

   function automatic rsp_type alu_predict(input req_type q);
      rsp_type     r;
      logic [63:0] m, a, b, xa, xb, sa, sb, ua, ub, qt;
      logic [3:0]  fl;
      logic [127:0] prod;
      int          w, amt;
      r  = '0;
      a  = q.op_a;
      b  = q.op_b;
      w  = q.size_64 ? 64 : 32;
      m  = q.size_64 ? ONES : LO32;
      xa = a & m;
      xb = b & m;
      amt = int'(b & 64'(w - 1));
      case (q.cmd)
         OP_ADD:  r.result = add_nzcv(a, b, 1'b0, q.size_64, fl);
         OP_ADC:  r.result = add_nzcv(a, b, q.cflag, q.size_64, fl);
         OP_ADDS: r.result = add_nzcv(a, b, 1'b0, q.size_64, r.flags_nzcv);
         OP_ADCS: r.result = add_nzcv(a, b, q.cflag, q.size_64, r.flags_nzcv);
         OP_SUB:  r.result = add_nzcv(a, ~b, 1'b1, q.size_64, fl);
         OP_SBC:  r.result = add_nzcv(a, ~b, q.cflag, q.size_64, fl);
         OP_SUBS: r.result = add_nzcv(a, ~b, 1'b1, q.size_64, r.flags_nzcv);
         OP_SBCS: r.result = add_nzcv(a, ~b, q.cflag, q.size_64, r.flags_nzcv);
         OP_AND, OP_ANDS: r.result = a & b;
         OP_BIC, OP_BICS: r.result = a & ~b;
         OP_ORR:  r.result = a | b;
         OP_ORN:  r.result = a | ~b;
         OP_EOR:  r.result = a ^ b;
         OP_EON:  r.result = a ^ ~b;
         OP_NOT, OP_MOVN: r.result = ~a;
         OP_LSL:  r.result = xa << amt;
         OP_LSR:  r.result = xa >> amt;
         OP_ASR:  r.result = 64'($signed(sext(xa, w)) >>> amt);
         OP_ROR:  r.result = (amt == 0) ? xa : ((xa >> amt) | (xa << (w - amt)));
         OP_SXTB: r.result = sext(a, 8);
         OP_SXTH: r.result = sext(a, 16);
         OP_SXTW: r.result = sext(a, 32);
         OP_UXTB: r.result = a & 64'hFF;
         OP_UXTH: r.result = a & 64'hFFFF;
         OP_UXTW: r.result = a & LO32;
         OP_MUL:  r.result = a * b;
         OP_UMULH: begin
            prod = {64'd0, a} * {64'd0, b};
            r.result = prod[127:64];
         end
         OP_SMULH: begin
            prod = 128'($signed(a)) * 128'($signed(b));
            r.result = prod[127:64];
         end
         OP_UMULL: r.result = (a & LO32) * (b & LO32);
         OP_SMULL: r.result = sext(a, 32) * sext(b, 32);
         OP_UDIV: r.result = (xb == 64'd0) ? 64'd0 : xa / xb;
         OP_SDIV: begin
            sa = sext(a, w);
            sb = sext(b, w);
            ua = sa[63] ? -sa : sa;
            ub = sb[63] ? -sb : sb;
            if (ub == 64'd0) begin
               r.result = 64'd0;
            end else begin
               qt = ua / ub;
               r.result = (sa[63] != sb[63]) ? -qt : qt;
            end
         end
         OP_MOV:  r.result = a;
         OP_MOVK: r.result = (b & q.op_c) | a;
         OP_OVERWRITE: r.result = (a & q.op_c) | b;
         OP_CONCAT32: begin
            r.result = {a[31:0], b[31:0]};
            r.wide_result = 1'b1;
         end
         OP_CONCAT64: begin
            r.result_high = a;
            r.result = b;
            r.wide_result = 1'b1;
         end
         default: ;
      endcase
      // size masking applies to everything except multiplies and concats
      if (q.cmd < OP_MUL || (q.cmd >= OP_UDIV && q.cmd <= OP_OVERWRITE))
         r.result = r.result & m;
      if (q.cmd == OP_ANDS || q.cmd == OP_BICS)
         r.flags_nzcv = {r.result[w-1], r.result == 64'd0, 2'b00};
      r.flags_valid = (q.cmd == OP_ADDS || q.cmd == OP_ADCS || q.cmd == OP_SUBS ||
                       q.cmd == OP_SBCS || q.cmd == OP_ANDS || q.cmd == OP_BICS);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Request driver: valid held until accepted, updates on falling edge
   // ---------------------------------------------------------------
   task automatic send_request(input req_type q, input bit has_want, input rsp_type want);
      rsp_type exp_rsp;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      exp_rsp = alu_predict(q);
      // typed expectations cross-check the predictor itself
      if (has_want && exp_rsp != want) report_mismatch("directed table", exp_rsp[63:0],
                                                        want[63:0]);
      pending_rsp.push_back(has_want ? want : exp_rsp);
      n_sent++;
      if (exp_rsp.flags_valid) n_flag_ops++;
      if (q.cmd == OP_UDIV || q.cmd == OP_SDIV) n_div_ops++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // Response side: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || hold_off)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.result, 64'd0);
         end else begin
            want = pending_rsp.pop_front();
            n_checked++;
            if (rsp_data.result !== want.result)
               report_mismatch("result", rsp_data.result, want.result);
            if (rsp_data.result_high !== want.result_high)
               report_mismatch("result_high", rsp_data.result_high, want.result_high);
            if (rsp_data.wide_result !== want.wide_result)
               report_mismatch("wide_result", 64'(rsp_data.wide_result),
                               64'(want.wide_result));
            if (rsp_data.flags_nzcv !== want.flags_nzcv)
               report_mismatch("flags_nzcv", 64'(rsp_data.flags_nzcv), 64'(want.flags_nzcv));
            if (rsp_data.flags_valid !== want.flags_valid)
               report_mismatch("flags_valid", 64'(rsp_data.flags_valid),
                               64'(want.flags_valid));
         end
      end
   end

   // Long receiver hold-off counted in its own process while requests keep coming
   initial begin
      int k;
      wait (n_sent == 40);
      @(negedge clock);
      hold_off = 1'b1;
      for (k = 0; k < 200; k++) @(negedge clock);
      hold_off = 1'b0;
   end

   // ---------------------------------------------------------------
   // Random request generation, biased toward corner operand values
   // ---------------------------------------------------------------
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(9))
         0: return 64'd0;
         1: return ONES;
         2: return MIN64;
         3: return MIN32;
         4: return LO32;
         5: return 64'($urandom_range(70));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_request();
      req_type q;
      q.cmd      = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 40))
                                             : 6'($urandom_range(39));
      q.op_a     = pick_operand();
      q.op_b     = pick_operand();
      q.op_c     = {$urandom, $urandom};
      q.size_64  = 1'($urandom);
      q.cflag    = 1'($urandom);
      return q;
   endfunction

   // ---------------------------------------------------------------
   // Directed table: rows with a typed-in result where it is obvious
   // ---------------------------------------------------------------
   typedef struct {
      req_type q;
      bit      has_want;
      rsp_type want;
   } vec_row;

   function automatic vec_row mkrow(input logic [5:0] cmd, input logic [63:0] a,
                                    input logic [63:0] b, input logic [63:0] c,
                                    input logic s64, input logic cin, input bit has,
                                    input logic [63:0] res, input logic [63:0] hi,
                                    input logic wide, input logic [3:0] nzcv,
                                    input logic fv);
      vec_row v;
      v.q        = '{cmd: cmd, op_a: a, op_b: b, op_c: c, size_64: s64, cflag: cin};
      v.has_want = has;
      v.want     = '{result: res, result_high: hi, wide_result: wide,
                     flags_nzcv: nzcv, flags_valid: fv};
      return v;
   endfunction

   initial begin
      vec_row  dir_table[$];
      req_type q;
      int      i, ph;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // add overflow to zero: Z and C set
      dir_table.push_back(mkrow(OP_ADDS, ONES, 64'd1, 0, 1, 0, 1, 0, 0, 0, 4'b0110, 1));
      // signed overflow at 32 bits
      dir_table.push_back(mkrow(OP_ADDS, 64'h7FFF_FFFF, 64'd1, 0, 0, 0, 1,
                                MIN32, 0, 0, 4'b1001, 1));
      dir_table.push_back(mkrow(OP_ADCS, ONES, ONES, 0, 1, 1, 0, 0, 0, 0, 0, 0));
      // equal operands compare: Z and C
      dir_table.push_back(mkrow(OP_SUBS, 64'd5, 64'd5, 0, 1, 0, 1, 0, 0, 0, 4'b0110, 1));
      dir_table.push_back(mkrow(OP_SBCS, MIN64, 64'd1, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_SBC, 64'd0, ONES, 0, 0, 1, 0, 0, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_ANDS, MIN64, ONES, 0, 1, 1, 1, MIN64, 0, 0, 4'b1000, 1));
      dir_table.push_back(mkrow(OP_BICS, ONES, ONES, 0, 0, 1, 1, 0, 0, 0, 4'b0100, 1));
      // xor-not with equal operands gives all ones
      dir_table.push_back(mkrow(OP_EON, 64'h1234, 64'h1234, 0, 1, 0, 1,
                                ONES, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_ORN, 64'd0, ONES, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      // shift amount wraps modulo the size
      dir_table.push_back(mkrow(OP_LSL, 64'd1, 64'd64, 0, 1, 0, 1, 64'd1, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_LSR, ONES, 64'd31, 0, 0, 0, 1, 64'd1, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_ASR, MIN32, 64'd31, 0, 0, 0, 1, LO32, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_ROR, 64'd1, 64'd1, 0, 1, 0, 1, MIN64, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_SXTB, 64'h80, 0, 0, 1, 0, 1,
                                64'hFFFF_FFFF_FFFF_FF80, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_UMULH, ONES, ONES, 0, 0, 0, 1,
                                64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_SMULH, ONES, ONES, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_SMULL, LO32, MIN32, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      // divide by zero yields zero
      dir_table.push_back(mkrow(OP_UDIV, ONES, 64'd0, 0, 1, 0, 1, 0, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_SDIV, ONES, 64'd0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      // most negative over minus one gives the most negative value back
      dir_table.push_back(mkrow(OP_SDIV, MIN64, ONES, 0, 1, 0, 1, MIN64, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_SDIV, MIN32, ONES, 0, 0, 0, 1, MIN32, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_MOVK, 64'h00AB_0000, ONES, 64'hFF00_FFFF, 1, 0, 1,
                                64'hFFAB_FFFF, 0, 0, 0, 0));
      dir_table.push_back(mkrow(OP_CONCAT64, ONES, 64'd7, 0, 0, 0, 1,
                                64'd7, ONES, 1, 0, 0));
      // unused opcodes give all zero
      dir_table.push_back(mkrow(6'd63, ONES, ONES, ONES, 1, 1, 1, 0, 0, 0, 0, 0));
      // every defined opcode once more, checked against the predictor
      for (i = 0; i < OP_FIRST_UNUSED; i++)
         dir_table.push_back(mkrow(6'(i), 64'hF0F0_1234_8765_ABCD, 64'h0000_0000_0000_0023,
                                   64'h0FF0_0FF0_0FF0_0FF0, 1'(i), 1'(~i), 0, 0, 0, 0, 0, 0));

      recv_idle_pct = 0;
      foreach (dir_table[k]) send_request(dir_table[k].q, dir_table[k].has_want,
                                          dir_table[k].want);

      // three idling phases over the random requests
      for (ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 47 : 0;
         recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 15 : 0;
         for (i = 0; i < N_RANDOM / 3; i++) begin
            q = random_request();
            // keep divides rarer: each one blocks the unit for many cycles
            if ((q.cmd == OP_UDIV || q.cmd == OP_SDIV) && $urandom_range(2) != 0)
               q.cmd = OP_MUL;
            send_request(q, 0, '0);
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // End of run: drain, settle, report
   initial begin
      int k;
      wait (stim_done);
      while (pending_rsp.size() != 0) @(posedge clock);
      for (k = 0; k < 100; k++) @(posedge clock);
      $display("Sent %0d requests, %0d responses checked (%0d flag-setting, %0d divides),",
               n_sent, n_checked, n_flag_ops, n_div_ops);
      $display("under sender/receiver stalls and one long response hold-off.");
      if (n_errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog: far above the slowest legal run
   initial begin
      #(12 * 400000);
      $display("timeout waiting for responses");
      $display("TEST FAILED");
      $finish;
   end

endmodule
